// ----- rtl/fvd_pkg.sv -----
package fvd_pkg;

  // field widths
  localparam int unsigned BoxW    = 10;
  localparam int unsigned DepthW  = 16;
  localparam int unsigned CentreW = 11;
  localparam int unsigned SpeedW  = 12;
  localparam int unsigned LimW    = 11;
  localparam int unsigned SlopeW  = 12;
  localparam int unsigned OffsetW = 13;
  localparam int unsigned CfgDataW = 16;

  // depth sample fields carried by one item
  localparam int unsigned NumDepthFields      = 5;
  localparam int unsigned DefaultDepthSamples = 5;

  // centre bands in pixels
  localparam logic [CentreW-1:0] BandLeft1  = 11'd100;
  localparam logic [CentreW-1:0] BandLeft2  = 11'd300;
  localparam logic [CentreW-1:0] BandRight1 = 11'd340;
  localparam logic [CentreW-1:0] BandRight2 = 11'd540;

  // rotation base terms, 1.2 and 1.36 in Q16
  localparam int unsigned RotBaseW = 17;
  localparam logic [RotBaseW-1:0] RotBaseLeft  = 17'd78643;
  localparam logic [RotBaseW-1:0] RotBaseRight = 17'd89129;

  // reciprocal table for the mean: ceil(2^24 / n), exact floor for sums up to 2^20
  localparam int unsigned RecipShift = 24;
  localparam int unsigned RecipW     = 25;
  localparam int unsigned RecipIdxW  = 3;
  localparam logic [RecipW-1:0] RecipTable [2**RecipIdxW] = '{
    25'd0,
    25'd16777216,
    25'd8388608,
    25'd5592406,
    25'd4194304,
    25'd3355444,
    25'd2796203,
    25'd2396746
  };

  typedef enum logic [2:0] {
    REG_MIN_VALID_DEPTH = 3'd0,
    REG_FAR_LIMIT       = 3'd1,
    REG_NEAR_LIMIT      = 3'd2,
    REG_FWD_LIMIT       = 3'd3,
    REG_TURN_LIMIT      = 3'd4,
    REG_LINEAR_SLOPE    = 3'd5,
    REG_LINEAR_OFFSET   = 3'd6,
    REG_ROTATION_SLOPE  = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BAND_FULL_LEFT,
    BAND_LEFT,
    BAND_DEAD,
    BAND_RIGHT,
    BAND_FULL_RIGHT
  } rot_band_e;

  typedef struct packed {
    logic [DepthW-1:0]         min_valid_depth;
    logic [DepthW-1:0]         far_limit;
    logic [DepthW-1:0]         near_limit;
    logic [LimW-1:0]           fwd_limit;
    logic [LimW-1:0]           turn_limit;
    logic [SlopeW-1:0]         linear_slope;
    logic signed [OffsetW-1:0] linear_offset;
    logic [SlopeW-1:0]         rotation_slope;
  } fvd_cfg_t;

  localparam fvd_cfg_t CfgReset = '{
    min_valid_depth: 16'd819,
    far_limit:       16'd3072,
    near_limit:      16'd1331,
    fwd_limit:       11'd307,
    turn_limit:      11'd768,
    linear_slope:    12'd120,
    linear_offset:   -13'sd54,
    rotation_slope:  12'd262
  };

  // load strobes of the first two pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
  } fvd_stage_en_t;

endpackage

// ----- rtl/fvd_in_if.sv -----
interface fvd_in_if;
  import fvd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BoxW-1:0]   box_left;
  logic [BoxW-1:0]   box_width;
  logic [DepthW-1:0] depth_a;
  logic [DepthW-1:0] depth_b;
  logic [DepthW-1:0] depth_c;
  logic [DepthW-1:0] depth_d;
  logic [DepthW-1:0] depth_e;

  modport source (
    output valid, box_left, box_width, depth_a, depth_b, depth_c, depth_d, depth_e,
    input  ready
  );
  modport sink (
    input  valid, box_left, box_width, depth_a, depth_b, depth_c, depth_d, depth_e,
    output ready
  );
endinterface

// ----- rtl/fvd_out_if.sv -----
interface fvd_out_if;
  import fvd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [SpeedW-1:0] fwd_speed;
  logic signed [SpeedW-1:0] turn_speed;
  logic [DepthW-1:0]        mean_distance;
  logic                     off_target_warning;
  logic                     target_lost;

  modport source (
    output valid, fwd_speed, turn_speed, mean_distance, off_target_warning,
           target_lost,
    input  ready
  );
  modport sink (
    input  valid, fwd_speed, turn_speed, mean_distance, off_target_warning,
           target_lost,
    output ready
  );
endinterface

// ----- rtl/fvd_cfg_if.sv -----
interface fvd_cfg_if;
  import fvd_pkg::*;

  logic                valid;
  logic                ready;
  cfg_reg_e            index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/fvd_rotation.sv -----
module fvd_rotation (
  input  logic                             clk_i,
  input  fvd_pkg::fvd_stage_en_t           en_i,
  input  logic [fvd_pkg::BoxW-1:0]         box_left_i,
  input  logic [fvd_pkg::BoxW-1:0]         box_width_i,
  input  fvd_pkg::fvd_cfg_t                cfg_i,
  output logic signed [fvd_pkg::SpeedW-1:0] rot_o,
  output logic                             warn_o
);
  import fvd_pkg::*;

  localparam int unsigned ProdW = SlopeW + CentreW;
  localparam int unsigned AccW  = ProdW + 2;
  localparam int unsigned ShW   = AccW - 6;

  logic [CentreW-1:0] centre;
  rot_band_e          band_d, band_q;
  logic [ProdW-1:0]   prod_d, prod_q;

  logic [RotBaseW-1:0]      base;
  logic signed [AccW-1:0]   acc;
  logic signed [ShW-1:0]    shifted;
  logic signed [SpeedW-1:0] lin_rot;
  logic signed [SpeedW-1:0] rot_d, rot_q;
  logic                     warn_d, warn_q;

  // stage 1: centre, band and slope product
  assign centre = {1'b0, box_left_i} + {2'b00, box_width_i[BoxW-1:1]};
  assign prod_d = ProdW'(cfg_i.rotation_slope) * ProdW'(centre);

  always_comb begin
    if (centre < BandLeft1) begin
      band_d = BAND_FULL_LEFT;
    end else if (centre > BandLeft1 && centre < BandLeft2) begin
      band_d = BAND_LEFT;
    end else if (centre > BandRight1 && centre < BandRight2) begin
      band_d = BAND_RIGHT;
    end else if (centre > BandRight2) begin
      band_d = BAND_FULL_RIGHT;
    end else begin
      band_d = BAND_DEAD;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      band_q <= band_d;
      prod_q <= prod_d;
    end
  end

  // stage 2: base minus product, round half up, saturate
  assign base    = (band_q == BAND_RIGHT) ? RotBaseRight : RotBaseLeft;
  assign acc     = $signed(AccW'(base)) - $signed(AccW'(prod_q)) + AccW'(32);
  assign shifted = acc[AccW-1:6];

  always_comb begin
    if (shifted > $signed(ShW'(2047))) begin
      lin_rot = 12'sd2047;
    end else if (shifted < -$signed(ShW'(2048))) begin
      lin_rot = {1'b1, {(SpeedW-1){1'b0}}};
    end else begin
      lin_rot = shifted[SpeedW-1:0];
    end
  end

  always_comb begin
    rot_d  = '0;
    warn_d = 1'b0;
    case (band_q)
      BAND_FULL_LEFT: begin
        rot_d  = $signed({1'b0, cfg_i.turn_limit});
        warn_d = 1'b1;
      end
      BAND_FULL_RIGHT: begin
        rot_d  = -$signed({1'b0, cfg_i.turn_limit});
        warn_d = 1'b1;
      end
      BAND_LEFT, BAND_RIGHT: rot_d = lin_rot;
      default: rot_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      rot_q  <= rot_d;
      warn_q <= warn_d;
    end
  end

  assign rot_o  = rot_q;
  assign warn_o = warn_q;

endmodule

// ----- rtl/follower_velocity_from_depth_core.sv -----
// drive command for a target follower, one result per measurement
// in_i carries the box left edge and width and five depth samples (Q10 metres);
// out_o returns forward and turn speed, the mean valid depth and two flags
// cfg_i writes the eight tuning registers by index; it is always ready and
// should only be used while no item is in flight
// every channel moves one transfer at a rising edge with valid and ready high
// a result is offered from the last of four register stages, the first of them
// loaded at the input transfer
// throughput: one item per cycle while the receiver keeps taking results;
// stage 1 masks and sums the samples and forms the rotation product,
// stage 2 divides by the sample count through a reciprocal multiply and
// finishes rotation, stage 3 multiplies by the linear slope, stage 4 rounds,
// clamps and holds the result for the receiver
// each stage advances when it is empty or the next one advances, so while the
// receiver stalls the pipeline fills up to four items before in_i drops
// ready; nothing is lost or repeated
// reset empties the pipeline and loads the default register values
module follower_velocity_from_depth_core #(
  parameter int unsigned DepthSamples = fvd_pkg::DefaultDepthSamples
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fvd_in_if.sink       in_i,
  fvd_out_if.source    out_o,
  fvd_cfg_if.sink      cfg_i
);
  import fvd_pkg::*;

  // only the first DepthSamples depth fields take part
  localparam int unsigned NumUsed =
    (DepthSamples < NumDepthFields) ? DepthSamples : NumDepthFields;
  localparam int unsigned CntW    = $clog2(NumUsed + 1);
  localparam int unsigned SumW    = DepthW + CntW;
  localparam int unsigned QuotW   = SumW + RecipW;
  localparam int unsigned LProdW  = DepthW + SlopeW;
  localparam int unsigned LAccW   = LProdW + 2;
  localparam int unsigned LShW    = LAccW - 10;

  // configuration registers
  fvd_cfg_t cfg_d, cfg_q;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        REG_MIN_VALID_DEPTH: cfg_d.min_valid_depth = cfg_i.data;
        REG_FAR_LIMIT:       cfg_d.far_limit       = cfg_i.data;
        REG_NEAR_LIMIT:      cfg_d.near_limit      = cfg_i.data;
        REG_FWD_LIMIT:       cfg_d.fwd_limit       = cfg_i.data[LimW-1:0];
        REG_TURN_LIMIT:      cfg_d.turn_limit      = cfg_i.data[LimW-1:0];
        REG_LINEAR_SLOPE:    cfg_d.linear_slope    = cfg_i.data[SlopeW-1:0];
        REG_LINEAR_OFFSET:   cfg_d.linear_offset   = $signed(cfg_i.data[OffsetW-1:0]);
        REG_ROTATION_SLOPE:  cfg_d.rotation_slope  = cfg_i.data[SlopeW-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // pipeline control: a stage moves when it is empty or its successor moves
  logic [3:0] vld_d, vld_q;
  logic [3:0] adv;
  logic [3:0] load;

  assign adv[3] = !vld_q[3] || out_o.ready;
  assign adv[2] = !vld_q[2] || adv[3];
  assign adv[1] = !vld_q[1] || adv[2];
  assign adv[0] = !vld_q[0] || adv[1];

  assign in_i.ready = adv[0];

  assign load[0] = adv[0] && in_i.valid;
  assign load[1] = adv[1] && vld_q[0];
  assign load[2] = adv[2] && vld_q[1];
  assign load[3] = adv[3] && vld_q[2];

  assign vld_d[0] = adv[0] ? in_i.valid : vld_q[0];
  assign vld_d[1] = adv[1] ? vld_q[0]   : vld_q[1];
  assign vld_d[2] = adv[2] ? vld_q[1]   : vld_q[2];
  assign vld_d[3] = adv[3] ? vld_q[2]   : vld_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // rotation path runs alongside stages 1 and 2
  fvd_stage_en_t            rot_en;
  logic signed [SpeedW-1:0] rot_s2;
  logic                     warn_s2;

  assign rot_en.s1 = load[0];
  assign rot_en.s2 = load[1];

  fvd_rotation u_rotation (
    .clk_i       (clk_i),
    .en_i        (rot_en),
    .box_left_i  (in_i.box_left),
    .box_width_i (in_i.box_width),
    .cfg_i       (cfg_q),
    .rot_o       (rot_s2),
    .warn_o      (warn_s2)
  );

  // stage 1: window test on each sample, sum and count
  logic [NumDepthFields-1:0][DepthW-1:0] depth;
  logic [NumUsed-1:0]                    in_win;
  logic [SumW-1:0]                       sum_d, sum_q1;
  logic [CntW-1:0]                       cnt_d;
  logic [RecipW-1:0]                     recip_q1;
  logic                                  none_q1;

  assign depth = {in_i.depth_e, in_i.depth_d, in_i.depth_c, in_i.depth_b, in_i.depth_a};

  always_comb begin
    sum_d = '0;
    cnt_d = '0;
    for (int i = 0; i < NumUsed; i++) begin
      in_win[i] = (depth[i] > cfg_q.min_valid_depth) && (depth[i] < cfg_q.far_limit);
      if (in_win[i]) begin
        sum_d = sum_d + SumW'(depth[i]);
        cnt_d = cnt_d + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      sum_q1   <= sum_d;
      recip_q1 <= RecipTable[RecipIdxW'(cnt_d)];
      none_q1  <= (cnt_d == '0);
    end
  end

  // stage 2: mean as sum times reciprocal of the count
  logic [QuotW-1:0]  quot;
  logic [DepthW-1:0] mean_q2;
  logic              none_q2;

  assign quot = QuotW'(sum_q1) * QuotW'(recip_q1);

  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      mean_q2 <= quot[RecipShift +: DepthW];
      none_q2 <= none_q1;
    end
  end

  // stage 3: lost test and distance times slope
  logic [LProdW-1:0]        lprod_q3;
  logic                     mirror_q3;
  logic                     lost_q3;
  logic [DepthW-1:0]        mean_q3;
  logic signed [SpeedW-1:0] rot_q3;
  logic                     warn_q3;

  always_ff @(posedge clk_i) begin
    if (load[2]) begin
      lprod_q3  <= LProdW'(mean_q2) * LProdW'(cfg_q.linear_slope);
      mirror_q3 <= mean_q2 < cfg_q.near_limit;
      lost_q3   <= none_q2 || (mean_q2 >= cfg_q.far_limit);
      mean_q3   <= mean_q2;
      rot_q3    <= rot_s2;
      warn_q3   <= warn_s2;
    end
  end

  // stage 4: mirror, offset, round half up, symmetric clamp
  logic signed [LAccW-1:0]  lterm;
  logic signed [LAccW-1:0]  lacc;
  logic signed [LShW-1:0]   lshift;
  logic signed [LShW-1:0]   lim;
  logic signed [SpeedW-1:0] lin_d;
  logic signed [SpeedW-1:0] rot_d;

  logic signed [SpeedW-1:0] lin_q4;
  logic signed [SpeedW-1:0] rot_q4;
  logic [DepthW-1:0]        mean_q4;
  logic                     warn_q4;
  logic                     lost_q4;

  assign lterm  = mirror_q3 ? -$signed(LAccW'(lprod_q3)) : $signed(LAccW'(lprod_q3));
  assign lacc   = lterm + ($signed(LAccW'(cfg_q.linear_offset)) <<< 10) + LAccW'(512);
  assign lshift = lacc[LAccW-1:10];
  assign lim    = $signed(LShW'(cfg_q.fwd_limit));

  always_comb begin
    if (lost_q3) begin
      lin_d = '0;
    end else if (lshift > lim) begin
      lin_d = lim[SpeedW-1:0];
    end else if (lshift < -lim) begin
      lin_d = -lim[SpeedW-1:0];
    end else begin
      lin_d = lshift[SpeedW-1:0];
    end
    rot_d = lost_q3 ? '0 : rot_q3;
  end

  always_ff @(posedge clk_i) begin
    if (load[3]) begin
      lin_q4  <= lin_d;
      rot_q4  <= rot_d;
      mean_q4 <= mean_q3;
      warn_q4 <= warn_q3;
      lost_q4 <= lost_q3;
    end
  end

  assign out_o.valid              = vld_q[3];
  assign out_o.fwd_speed          = lin_q4;
  assign out_o.turn_speed         = rot_q4;
  assign out_o.mean_distance      = mean_q4;
  assign out_o.off_target_warning = warn_q4;
  assign out_o.target_lost        = lost_q4;

endmodule

// ----- tb/tb_follower_velocity_from_depth_core.sv -----
`timescale 1ns / 1ps

module tb_follower_velocity_from_depth_core;
  import fvd_pkg::*;

  // quiet cycles tolerated before the run is declared hung
  localparam int IdleLimit   = 4000;
  localparam int PhaseItems  = 250;
  localparam int NumPhases   = 7;
  // sender gap ceiling and receiver stall percentage per phase
  localparam int GapTab   [NumPhases] = '{0, 3, 8, 0, 5, 2, 12};
  localparam int StallTab [NumPhases] = '{0, 25, 50, 0, 10, 70, 30};

  // one measurement as offered on the input channel, depth[0] is sample a
  typedef struct packed {
    logic [BoxW-1:0]                        box_left;
    logic [BoxW-1:0]                        box_width;
    logic [NumDepthFields-1:0][DepthW-1:0]  depth;
  } meas_t;

  // one drive command as returned on the output channel
  typedef struct packed {
    logic signed [SpeedW-1:0] fwd_speed;
    logic signed [SpeedW-1:0] turn_speed;
    logic [DepthW-1:0]        mean_distance;
    logic                     off_target_warning;
    logic                     target_lost;
  } drive_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  fvd_in_if  meas_if ();
  fvd_out_if cmd_if ();
  fvd_cfg_if cfg_if ();

  follower_velocity_from_depth_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (meas_if),
    .out_o  (cmd_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // measurements waiting to be offered, and drive commands still owed by the block
  meas_t      meas_q [$];
  drive_cmd_t cmd_q  [$];

  // register values as the block should hold them
  fvd_cfg_t tune = CfgReset;

  int max_gap   = 0;
  int stall_pct = 0;
  int errors    = 0;
  int sent      = 0;
  int checked   = 0;
  int lost_seen = 0;
  int warn_seen = 0;
  int settings  = 1;

  // a toggle here asks the receiver for one long hold-off
  logic squeeze_req = 1'b0;
  logic squeeze_ack;
  int   hold_left;
  int   burst_left;
  int   gap_left;
  int   quiet = 0;

  // expected drive command for one measurement under the given registers
  function automatic drive_cmd_t drive_cmd_of(input meas_t m, input fvd_cfg_t k);
    drive_cmd_t r;
    longint sum, cnt, mean, centre, rot, lin, prod, lim;
    int n;
    sum  = 0;
    cnt  = 0;
    mean = 0;
    n = int'((DefaultDepthSamples < NumDepthFields) ? DefaultDepthSamples : NumDepthFields);
    // only samples strictly inside the window count
    for (int i = 0; i < n; i++) begin
      if (m.depth[i] > k.min_valid_depth && m.depth[i] < k.far_limit) begin
        sum += longint'(m.depth[i]);
        cnt++;
      end
    end
    if (cnt != 0) mean = sum / cnt;

    centre = longint'(m.box_left) + longint'(m.box_width >> 1);
    r.off_target_warning = 1'b0;
    r.target_lost        = 1'b0;
    if (centre < longint'(BandLeft1)) begin
      rot = longint'(k.turn_limit);
      r.off_target_warning = 1'b1;
    end else if (centre > longint'(BandLeft1) && centre < longint'(BandLeft2)) begin
      rot = (longint'(RotBaseLeft) - longint'(k.rotation_slope) * centre + 32) >>> 6;
    end else if (centre > longint'(BandRight1) && centre < longint'(BandRight2)) begin
      rot = (longint'(RotBaseRight) - longint'(k.rotation_slope) * centre + 32) >>> 6;
    end else if (centre > longint'(BandRight2)) begin
      rot = -longint'(k.turn_limit);
      r.off_target_warning = 1'b1;
    end else begin
      rot = 0;
    end
    if (rot < -2048) rot = -2048;
    else if (rot > 2047) rot = 2047;

    if (cnt == 0 || mean >= longint'(k.far_limit)) begin
      // target lost, warning still follows the band
      lin = 0;
      rot = 0;
      r.target_lost = 1'b1;
    end else begin
      prod = mean * longint'(k.linear_slope);
      lim  = longint'(k.fwd_limit);
      // mirrored law when closer than the near limit
      if (mean < longint'(k.near_limit)) prod = -prod;
      lin = (prod + longint'(k.linear_offset) * 1024 + 512) >>> 10;
      if (lin > lim) lin = lim;
      else if (lin < -lim) lin = -lim;
    end

    r.fwd_speed     = lin[SpeedW-1:0];
    r.turn_speed    = rot[SpeedW-1:0];
    r.mean_distance = mean[DepthW-1:0];
    return r;
  endfunction

  // random measurement, depths mostly inside or on the edge of the window
  function automatic meas_t random_meas(input fvd_cfg_t k);
    meas_t m;
    int lo, hi;
    lo = int'(k.min_valid_depth);
    hi = int'(k.far_limit);
    if ($urandom_range(0, 3) == 0) begin
      m.box_left  = BoxW'($urandom_range(0, 1023));
      m.box_width = BoxW'($urandom_range(0, 1023));
    end else begin
      // centre mostly within reach of every band
      m.box_left  = BoxW'($urandom_range(0, 620));
      m.box_width = BoxW'($urandom_range(0, 120));
    end
    for (int i = 0; i < NumDepthFields; i++) begin
      case ($urandom_range(0, 9))
        0: m.depth[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        1: begin
          case ($urandom_range(0, 3))
            0: m.depth[i] = DepthW'(lo);
            1: m.depth[i] = DepthW'(lo + 1);
            2: m.depth[i] = DepthW'(hi - 1);
            default: m.depth[i] = DepthW'(hi);
          endcase
        end
        2, 3: m.depth[i] = DepthW'($urandom_range(0, 65535));
        default: m.depth[i] = (hi > lo + 1) ? DepthW'($urandom_range(lo + 1, hi - 1))
                                            : DepthW'($urandom_range(0, 65535));
      endcase
    end
    // now and then nothing usable at all
    if ($urandom_range(0, 15) == 0) m.depth = '0;
    return m;
  endfunction

  task automatic add_meas(input int left, input int width, input int a, input int b,
                          input int c, input int d, input int e);
    meas_t m;
    m.box_left  = BoxW'(left);
    m.box_width = BoxW'(width);
    m.depth[0]  = DepthW'(a);
    m.depth[1]  = DepthW'(b);
    m.depth[2]  = DepthW'(c);
    m.depth[3]  = DepthW'(d);
    m.depth[4]  = DepthW'(e);
    meas_q.push_back(m);
  endtask

  // one register transfer; called at a rising edge, returns at the accepting edge
  // with valid still high so that back-to-back writes need no re-raise
  task automatic set_reg(input cfg_reg_e sel, input logic [CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= sel;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (sel)
      REG_MIN_VALID_DEPTH: tune.min_valid_depth = val;
      REG_FAR_LIMIT:       tune.far_limit       = val;
      REG_NEAR_LIMIT:      tune.near_limit      = val;
      REG_FWD_LIMIT:       tune.fwd_limit       = val[LimW-1:0];
      REG_TURN_LIMIT:      tune.turn_limit      = val[LimW-1:0];
      REG_LINEAR_SLOPE:    tune.linear_slope    = val[SlopeW-1:0];
      REG_LINEAR_OFFSET:   tune.linear_offset   = val[OffsetW-1:0];
      REG_ROTATION_SLOPE:  tune.rotation_slope  = val[SlopeW-1:0];
      default: ;
    endcase
  endtask

  task automatic report(input string field, input longint want_v, input longint got_v);
    errors++;
    $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
  endtask

  // sender: bursts of random length, random gaps, valid held until the transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      meas_if.valid     <= 1'b0;
      meas_if.box_left  <= '0;
      meas_if.box_width <= '0;
      meas_if.depth_a   <= '0;
      meas_if.depth_b   <= '0;
      meas_if.depth_c   <= '0;
      meas_if.depth_d   <= '0;
      meas_if.depth_e   <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (meas_if.valid && meas_if.ready) begin
        cmd_q.push_back(drive_cmd_of(meas_q.pop_front(), tune));
        sent++;
      end
      if (!meas_if.valid || meas_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          meas_if.valid <= 1'b0;
        end else if (meas_q.size() != 0) begin
          meas_if.valid     <= 1'b1;
          meas_if.box_left  <= meas_q[0].box_left;
          meas_if.box_width <= meas_q[0].box_width;
          meas_if.depth_a   <= meas_q[0].depth[0];
          meas_if.depth_b   <= meas_q[0].depth[1];
          meas_if.depth_c   <= meas_q[0].depth[2];
          meas_if.depth_d   <= meas_q[0].depth[3];
          meas_if.depth_e   <= meas_q[0].depth[4];
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
          end else begin
            burst_left--;
          end
        end else begin
          meas_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls at the phase's rate, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cmd_if.ready <= 1'b0;
      hold_left   = 0;
      squeeze_ack = squeeze_req;
    end else begin
      if (squeeze_req != squeeze_ack) begin
        squeeze_ack = squeeze_req;
        hold_left   = 80;
      end
      if (hold_left != 0) begin
        hold_left--;
        cmd_if.ready <= 1'b0;
      end else begin
        cmd_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // checker: every drive command against the oldest expectation
  always @(posedge clk_i) begin
    drive_cmd_t want;
    if (rst_ni && cmd_if.valid && cmd_if.ready) begin
      if (cmd_q.size() == 0) begin
        errors++;
        $display("%0t: drive command with none expected, forward %0d turn %0d mean %0d",
                 $time, cmd_if.fwd_speed, cmd_if.turn_speed, cmd_if.mean_distance);
      end else begin
        want = cmd_q.pop_front();
        checked++;
        if (want.target_lost) lost_seen++;
        if (want.off_target_warning) warn_seen++;
        if (cmd_if.fwd_speed !== want.fwd_speed)
          report("fwd_speed", want.fwd_speed, cmd_if.fwd_speed);
        if (cmd_if.turn_speed !== want.turn_speed)
          report("turn_speed", want.turn_speed, cmd_if.turn_speed);
        if (cmd_if.mean_distance !== want.mean_distance)
          report("mean_distance", want.mean_distance, cmd_if.mean_distance);
        if (cmd_if.off_target_warning !== want.off_target_warning)
          report("off_target_warning", want.off_target_warning, cmd_if.off_target_warning);
        if (cmd_if.target_lost !== want.target_lost)
          report("target_lost", want.target_lost, cmd_if.target_lost);
      end
    end
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk_i) begin
    if ((meas_if.valid && meas_if.ready) || (cmd_if.valid && cmd_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet == IdleLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d commands still owed",
               $time, IdleLimit, cmd_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    cfg_reg_e            sel;
    logic [CfgDataW-1:0] val;
    int                  win_lo, win_hi, near;
    logic                hi_end, lo_end;

    rst_ni       = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_MIN_VALID_DEPTH;
    cfg_if.data  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < NumPhases; p++) begin
      max_gap   = GapTab[p];
      stall_pct = StallTab[p];

      if (p == 0) begin
        // reset values: every centre band edge and the window bounds
        add_meas(200, 40, 2000, 2000, 2000, 2000, 2000);
        add_meas(0, 0, 0, 0, 0, 0, 0);
        add_meas(1023, 1023, 65535, 65535, 65535, 65535, 65535);
        add_meas(99, 0, 819, 3072, 820, 3071, 1500);
        add_meas(100, 0, 900, 900, 900, 900, 900);
        add_meas(50, 101, 1331, 1331, 1331, 1331, 1331);
        add_meas(101, 0, 1330, 1330, 1330, 1330, 1330);
        add_meas(299, 0, 819, 819, 819, 819, 819);
        add_meas(300, 0, 3072, 3072, 3072, 3072, 3072);
        add_meas(320, 0, 2500, 0, 0, 0, 0);
        add_meas(340, 0, 1000, 2000, 3000, 0, 65535);
        add_meas(341, 0, 2900, 2950, 3000, 3050, 3071);
        add_meas(539, 0, 821, 822, 823, 824, 825);
        add_meas(540, 0, 2000, 2000, 2000, 2000, 2000);
        add_meas(541, 0, 2000, 1900, 1800, 1700, 1600);
        add_meas(1023, 0, 1400, 1400, 1400, 1400, 1400);
        add_meas(0, 1023, 1600, 1700, 1800, 1900, 2000);
        add_meas(512, 511, 0, 0, 0, 0, 0);
      end else begin
        // phase 1 drives the speed limits and slopes to their top, phase 2 to their bottom
        hi_end = (p == 1);
        lo_end = (p == 2);
        win_lo = $urandom_range(0, 3000);
        win_hi = win_lo + $urandom_range(2, 12000);
        near   = $urandom_range(win_lo, win_hi);
        sel = sel.first();
        do begin
          case (sel)
            REG_MIN_VALID_DEPTH: val = (hi_end || lo_end) ? 16'd0 : CfgDataW'(win_lo);
            REG_FAR_LIMIT:       val = (hi_end || lo_end) ? 16'hFFFF : CfgDataW'(win_hi);
            REG_NEAR_LIMIT:      val = hi_end ? 16'h8000 : lo_end ? 16'd0
                                               : CfgDataW'(near);
            REG_FWD_LIMIT:       val = hi_end ? 16'hFFFF : lo_end ? 16'd0
                                               : CfgDataW'($urandom_range(0, 1024));
            REG_TURN_LIMIT:      val = hi_end ? 16'hFFFF : lo_end ? 16'd0
                                               : CfgDataW'($urandom_range(0, 2047));
            REG_LINEAR_SLOPE:    val = hi_end ? 16'hFFFF : lo_end ? 16'd0
                                               : CfgDataW'($urandom_range(0, 4095));
            // most negative and most positive offset in 13 bit two's complement
            REG_LINEAR_OFFSET:   val = hi_end ? 16'h1000 : lo_end ? 16'h0FFF
                                               : CfgDataW'($urandom_range(0, 16'h1FFF));
            default:             val = hi_end ? 16'hFFFF : lo_end ? 16'd0
                                               : CfgDataW'($urandom_range(0, 4095));
          endcase
          // occasional raw 16 bit value, the block keeps only its width
          if (p >= 3 && $urandom_range(0, 9) == 0) val = CfgDataW'($urandom_range(0, 65535));
          set_reg(sel, val);
          sel = sel.next();
        end while (sel != sel.first());
        cfg_if.valid <= 1'b0;
        @(posedge clk_i);
        settings++;
      end

      for (int i = 0; i < PhaseItems; i++) meas_q.push_back(random_meas(tune));
      // long receiver hold-off while the sender keeps offering
      if (p == 3 || p == 5) squeeze_req = ~squeeze_req;

      // sender pauses here until the block has delivered everything
      while (meas_q.size() != 0 || meas_if.valid || cmd_q.size() != 0) @(posedge clk_i);
    end

    repeat (12) @(posedge clk_i);
    if (cmd_q.size() != 0) begin
      errors++;
      $display("%0t: %0d drive commands never arrived", $time, cmd_q.size());
    end
    $display("%0d measurements sent, %0d drive commands checked over %0d register settings",
             sent, checked, settings);
    $display("%0d with target lost, %0d with off-target warning", lost_seen, warn_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- follower_velocity_from_depth_core.f -----
rtl/fvd_pkg.sv
rtl/fvd_in_if.sv
rtl/fvd_out_if.sv
rtl/fvd_cfg_if.sv
rtl/fvd_rotation.sv
rtl/follower_velocity_from_depth_core.sv
tb/tb_follower_velocity_from_depth_core.sv
